>>> hdl/mst_pkg.sv
// ----------------------------------------------------------------------------
// mst_pkg
// Shared constants and types for the minimum spanning tree block.
// ----------------------------------------------------------------------------
package mst_pkg;

  localparam int VERTEX_BITS = 5;
  localparam int NUM_LABELS  = 2 ** VERTEX_BITS;
  localparam int COST_BITS   = 21;

  // one write into the component label store
  typedef struct packed {
    logic                   en;
    logic [VERTEX_BITS-1:0] addr;
    logic [VERTEX_BITS-1:0] data;
  } lbl_wr_t;

endpackage
// ----------------------------------------------------------------------------

>>> hdl/mst_edge_store.sv
// ----------------------------------------------------------------------------
// mst_edge_store
// Edge memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module mst_edge_store import mst_pkg::*; #(
  parameter int DEPTH = 496,
  parameter int WIDTH = 26,
  parameter int AW    = 9
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
// ----------------------------------------------------------------------------

>>> hdl/mst_label_store.sv
// ----------------------------------------------------------------------------
// mst_label_store
// Component label memory: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module mst_label_store import mst_pkg::*; (
  input  logic                   clk_i,
  input  lbl_wr_t                wr_i,
  input  logic [VERTEX_BITS-1:0] raddr_a_i,
  input  logic [VERTEX_BITS-1:0] raddr_b_i,
  output logic [VERTEX_BITS-1:0] rdata_a_o,
  output logic [VERTEX_BITS-1:0] rdata_b_o
);

  logic [VERTEX_BITS-1:0] mem [NUM_LABELS];
  logic [VERTEX_BITS-1:0] rdata_a_q;
  logic [VERTEX_BITS-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    rdata_a_q <= mem[raddr_a_i];
    rdata_b_q <= mem[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule
// ----------------------------------------------------------------------------

>>> hdl/minimum_spanning_tree_top.sv
// ----------------------------------------------------------------------------
// minimum_spanning_tree_top
// Kruskal minimum spanning tree over a loaded adjacency matrix.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+------------------------------
//  in      | input     | in_valid_i / in_stall_o    | row, column, weight, final
//  out     | output    | out_valid_o / out_stall_i  | from, to, weight, cost, flags
//  cfg     | input     | cfg_we_i                   | cfg_wdata_i (vertex count)
//
// Operation: matrix entries are taken one per cycle while loading. After the
// final entry the labels are seeded, then each scan pass reads the stored
// edges through the single read port of the edge memory; each candidate edge
// is looked up in the label store, and each accepted edge starts a label sweep.
// Passes run until the tree is complete or no edge is left.
// Reset clears control state; memory contents stay undefined until written.
// A stalled result holds in the output register; the sequencer waits on it
// only when it has another result to post.
// ----------------------------------------------------------------------------
module minimum_spanning_tree_top import mst_pkg::*; #(
  parameter int MAX_VERTICES = 32,
  parameter int WEIGHT_BITS  = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_we_i,
  input  logic [5:0]                    cfg_wdata_i,
  // matrix entries
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [VERTEX_BITS-1:0]        row_index_i,
  input  logic [VERTEX_BITS-1:0]        column_index_i,
  input  logic signed [WEIGHT_BITS-1:0] edge_weight_i,
  input  logic                          final_entry_i,
  // tree edges
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [VERTEX_BITS-1:0]        from_vertex_o,
  output logic [VERTEX_BITS-1:0]        to_vertex_o,
  output logic signed [WEIGHT_BITS-1:0] tree_edge_weight_o,
  output logic signed [COST_BITS-1:0]   running_cost_o,
  output logic                          edge_valid_o,
  output logic                          last_result_o
);

  localparam int EDGE_DEPTH = MAX_VERTICES * (MAX_VERTICES - 1) / 2;
  localparam int EA_W       = (EDGE_DEPTH > 1) ? $clog2(EDGE_DEPTH) : 1;
  localparam int ECNT_W     = $clog2(EDGE_DEPTH + 1);
  localparam int NV_W       = $clog2(MAX_VERTICES + 1);
  localparam int CAP_W      = 2 * NV_W;
  localparam int KEY_W      = WEIGHT_BITS + 2 * VERTEX_BITS;
  localparam int VB         = VERTEX_BITS;

  typedef enum logic [2:0] {
    S_LOAD, S_INIT, S_SCAN, S_LOOKUP, S_DECIDE, S_RELABEL, S_FINISH
  } state_e;

  state_e                  state_q;
  logic [5:0]              vc_q;
  logic [ECNT_W-1:0]       etot_q;
  logic [ECNT_W-1:0]       addr_q;
  logic                    rd_valid_q;
  logic [KEY_W-1:0]        best_q;
  logic                    found_q;
  logic [KEY_W-1:0]        last_q;
  logic                    have_last_q;
  logic [VB:0]             vcnt_q;
  logic                    rl_valid_q;
  logic [VB-1:0]           rl_addr_q;
  logic [VB-1:0]           keep_q;
  logic [VB-1:0]           drop_q;
  logic [VB:0]             tree_cnt_q;
  logic signed [COST_BITS-1:0] cost_q;
  logic                    pend_valid_q;
  logic [KEY_W-1:0]        pend_key_q;
  logic signed [COST_BITS-1:0] pend_cost_q;
  logic                    out_valid_q;
  logic [VB-1:0]           out_from_q;
  logic [VB-1:0]           out_to_q;
  logic [WEIGHT_BITS-1:0]  out_w_q;
  logic [COST_BITS-1:0]    out_cost_q;
  logic                    out_ev_q;
  logic                    out_last_q;

  logic [NV_W-1:0]         nv;
  logic [CAP_W-1:0]        cap_w;
  logic                    load_ok;
  logic [KEY_W-1:0]        in_key;
  logic [KEY_W-1:0]        rkey;
  logic                    scan_hit;
  logic                    out_free;
  logic [WEIGHT_BITS-1:0]  best_w;
  logic [63:0]             best_wext;
  logic [COST_BITS-1:0]    cost_n;
  logic [WEIGHT_BITS-1:0]  pend_w;
  lbl_wr_t                 lbl_wr;
  logic [VB-1:0]           lbl_ra;
  logic [VB-1:0]           lbl_rd_a;
  logic [VB-1:0]           lbl_rd_b;

  // active vertex count, clipped to the store size
  assign nv = (7'(vc_q) > 7'(MAX_VERTICES)) ? NV_W'(MAX_VERTICES) : NV_W'(vc_q);

  always_comb begin
    if (nv == '0) begin
      cap_w = '0;
    end else begin
      cap_w = (CAP_W'(nv) * CAP_W'(nv - 1'b1)) >> 1;
    end
  end

  // keep only entries below the diagonal, inside the graph, with a weight, up to nv*(nv-1)/2 of them
  assign load_ok = (column_index_i < row_index_i) && (8'(row_index_i) < 8'(nv)) &&
                   (edge_weight_i != '0) && (CAP_W'(etot_q) < cap_w);

  // sort key: weight with flipped sign bit, then row, then column
  assign in_key = {~edge_weight_i[WEIGHT_BITS-1], edge_weight_i[WEIGHT_BITS-2:0],
                   row_index_i, column_index_i};

  assign in_stall_o = (state_q != S_LOAD);
  assign out_free   = !out_valid_q || !out_stall_i;

  mst_edge_store #(
    .DEPTH (EDGE_DEPTH),
    .WIDTH (KEY_W),
    .AW    (EA_W)
  ) u_edge_store (
    .clk_i   (clk_i),
    .we_i    ((state_q == S_LOAD) && in_valid_i && load_ok),
    .waddr_i (etot_q[EA_W-1:0]),
    .wdata_i (in_key),
    .re_i    ((state_q == S_SCAN) && (addr_q < etot_q)),
    .raddr_i (addr_q[EA_W-1:0]),
    .rdata_o (rkey)
  );

  // smallest key above the last one taken, among edges still in the graph
  assign scan_hit = rd_valid_q && (8'(rkey[2*VB-1:VB]) < 8'(nv)) &&
                    (!have_last_q || (rkey > last_q)) &&
                    (!found_q || (rkey < best_q));

  assign best_w    = {~best_q[KEY_W-1], best_q[KEY_W-2:2*VB]};
  assign best_wext = {{(64-WEIGHT_BITS){best_w[WEIGHT_BITS-1]}}, best_w};
  assign cost_n    = cost_q + best_wext[COST_BITS-1:0];
  assign pend_w    = {~pend_key_q[KEY_W-1], pend_key_q[KEY_W-2:2*VB]};

  // label port a walks the vertices during relabel, else looks up the row
  assign lbl_ra = (state_q == S_RELABEL) ? vcnt_q[VB-1:0] : best_q[2*VB-1:VB];

  always_comb begin
    lbl_wr = '0;
    case (state_q)
      S_INIT: begin
        lbl_wr.en   = 1'b1;
        lbl_wr.addr = vcnt_q[VB-1:0];
        lbl_wr.data = vcnt_q[VB-1:0];
      end
      S_RELABEL: begin
        lbl_wr.en   = rl_valid_q && (lbl_rd_a == drop_q);
        lbl_wr.addr = rl_addr_q;
        lbl_wr.data = keep_q;
      end
      default: begin
        lbl_wr = '0;
      end
    endcase
  end

  mst_label_store u_label_store (
    .clk_i     (clk_i),
    .wr_i      (lbl_wr),
    .raddr_a_i (lbl_ra),
    .raddr_b_i (best_q[VB-1:0]),
    .rdata_a_o (lbl_rd_a),
    .rdata_b_o (lbl_rd_b)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_LOAD;
      vc_q         <= 6'd32;
      etot_q       <= '0;
      addr_q       <= '0;
      rd_valid_q   <= 1'b0;
      found_q      <= 1'b0;
      have_last_q  <= 1'b0;
      vcnt_q       <= '0;
      rl_valid_q   <= 1'b0;
      tree_cnt_q   <= '0;
      cost_q       <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        vc_q <= cfg_wdata_i;
      end
      // drop the result once taken
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      rd_valid_q <= 1'b0;
      rl_valid_q <= 1'b0;
      if (scan_hit) begin
        best_q  <= rkey;
        found_q <= 1'b1;
      end
      case (state_q)
        S_LOAD: begin
          if (in_valid_i) begin
            if (load_ok) begin
              etot_q <= etot_q + 1'b1;
            end
            if (final_entry_i) begin
              vcnt_q  <= '0;
              state_q <= S_INIT;
            end
          end
        end
        S_INIT: begin
          vcnt_q <= vcnt_q + 1'b1;
          if (vcnt_q == (VB+1)'(NUM_LABELS - 1)) begin
            addr_q      <= '0;
            found_q     <= 1'b0;
            have_last_q <= 1'b0;
            tree_cnt_q  <= '0;
            cost_q      <= '0;
            state_q     <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (addr_q < etot_q) begin
            addr_q     <= addr_q + 1'b1;
            rd_valid_q <= 1'b1;
          end else if (!rd_valid_q) begin
            state_q <= found_q ? S_LOOKUP : S_FINISH;
          end
        end
        S_LOOKUP: begin
          state_q <= S_DECIDE;
        end
        S_DECIDE: begin
          if (lbl_rd_a != lbl_rd_b) begin
            // hold until the previous tree edge can move to the output
            if (!pend_valid_q || out_free) begin
              if (pend_valid_q) begin
                out_valid_q <= 1'b1;
                out_from_q  <= pend_key_q[2*VB-1:VB];
                out_to_q    <= pend_key_q[VB-1:0];
                out_w_q     <= pend_w;
                out_cost_q  <= pend_cost_q;
                out_ev_q    <= 1'b1;
                out_last_q  <= 1'b0;
              end
              pend_valid_q <= 1'b1;
              pend_key_q   <= best_q;
              pend_cost_q  <= cost_n;
              cost_q       <= cost_n;
              tree_cnt_q   <= tree_cnt_q + 1'b1;
              keep_q       <= lbl_rd_a;
              drop_q       <= lbl_rd_b;
              vcnt_q       <= '0;
              state_q      <= S_RELABEL;
            end
          end else begin
            last_q      <= best_q;
            have_last_q <= 1'b1;
            addr_q      <= '0;
            found_q     <= 1'b0;
            state_q     <= S_SCAN;
          end
        end
        S_RELABEL: begin
          if (vcnt_q < (VB+1)'(NUM_LABELS)) begin
            vcnt_q     <= vcnt_q + 1'b1;
            rl_valid_q <= 1'b1;
            rl_addr_q  <= vcnt_q[VB-1:0];
          end else if (!rl_valid_q) begin
            if (8'(tree_cnt_q) == 8'(nv) - 8'd1) begin
              state_q <= S_FINISH;
            end else begin
              last_q      <= best_q;
              have_last_q <= 1'b1;
              addr_q      <= '0;
              found_q     <= 1'b0;
              state_q     <= S_SCAN;
            end
          end
        end
        S_FINISH: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_last_q  <= 1'b1;
            if (pend_valid_q) begin
              out_from_q <= pend_key_q[2*VB-1:VB];
              out_to_q   <= pend_key_q[VB-1:0];
              out_w_q    <= pend_w;
              out_cost_q <= pend_cost_q;
              out_ev_q   <= 1'b1;
            end else begin
              out_from_q <= '0;
              out_to_q   <= '0;
              out_w_q    <= '0;
              out_cost_q <= '0;
              out_ev_q   <= 1'b0;
            end
            pend_valid_q <= 1'b0;
            etot_q       <= '0;
            state_q      <= S_LOAD;
          end
        end
        default: begin
          state_q <= S_LOAD;
        end
      endcase
    end
  end

  assign out_valid_o        = out_valid_q;
  assign from_vertex_o      = out_from_q;
  assign to_vertex_o        = out_to_q;
  assign tree_edge_weight_o = out_w_q;
  assign running_cost_o     = out_cost_q;
  assign edge_valid_o       = out_ev_q;
  assign last_result_o      = out_last_q;

  a_etot_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    etot_q <= ECNT_W'(EDGE_DEPTH))
    else $error("edge count past store depth");

  a_tree_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tree_cnt_q <= (VB+1)'(NUM_LABELS - 1))
    else $error("tree edge count past vertex limit");

  a_pend_has_tree: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_valid_q |-> (tree_cnt_q != '0))
    else $error("pending tree edge without accepted edge");

  a_merge_distinct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RELABEL) |-> (keep_q != drop_q))
    else $error("relabel merges a component with itself");

  a_finish_to_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FINISH && out_free) |=> (state_q == S_LOAD && out_valid_q && out_last_q))
    else $error("run end did not post the last result");

endmodule
// ----------------------------------------------------------------------------

>>> test/minimum_spanning_tree_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// minimum_spanning_tree_checker
// Watches the entry and tree edge channels, predicts the tree edges of each
// loaded matrix and compares every result item field by field.
// ----------------------------------------------------------------------------
module minimum_spanning_tree_checker import mst_pkg::*; #(
  parameter int MAX_VERTICES = 32,
  parameter int WEIGHT_BITS  = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [5:0]                    cfg_wdata_i,
  input  logic                          in_valid_i,
  input  logic                          in_stall_o,
  input  logic [VERTEX_BITS-1:0]        row_index_i,
  input  logic [VERTEX_BITS-1:0]        column_index_i,
  input  logic signed [WEIGHT_BITS-1:0] edge_weight_i,
  input  logic                          final_entry_i,
  input  logic                          out_valid_o,
  input  logic                          out_stall_i,
  input  logic [VERTEX_BITS-1:0]        from_vertex_o,
  input  logic [VERTEX_BITS-1:0]        to_vertex_o,
  input  logic signed [WEIGHT_BITS-1:0] tree_edge_weight_o,
  input  logic signed [COST_BITS-1:0]   running_cost_o,
  input  logic                          edge_valid_o,
  input  logic                          last_result_o,
  output int                            fail_count,
  output int                            pending_count,
  output int                            tree_count
);

  localparam int EDGE_DEPTH = MAX_VERTICES * (MAX_VERTICES - 1) / 2;

  typedef struct {
    logic [VERTEX_BITS-1:0]        row;
    logic [VERTEX_BITS-1:0]        col;
    logic signed [WEIGHT_BITS-1:0] weight;
  } arc_t;

  typedef struct {
    logic [VERTEX_BITS-1:0]        from_v;
    logic [VERTEX_BITS-1:0]        to_v;
    logic signed [WEIGHT_BITS-1:0] weight;
    logic signed [COST_BITS-1:0]   cost;
    logic                          valid;
    logic                          last;
  } tree_edge_t;

  logic [5:0] vcount;
  arc_t       loaded_arcs[$];
  tree_edge_t tree_edges_due[$];

  assign pending_count = tree_edges_due.size();

  function automatic int active_count();
    return (vcount > MAX_VERTICES) ? MAX_VERTICES : int'(vcount);
  endfunction

  function automatic bit arc_precedes(arc_t a, arc_t b);
    if (a.weight != b.weight) return a.weight < b.weight;
    if (a.row != b.row) return a.row < b.row;
    return a.col < b.col;
  endfunction

  // sort, run Kruskal and queue the resulting tree edges
  task automatic build_tree();
    arc_t                        arcs[$];
    arc_t                        t;
    int                          nv, j, k, accepted;
    int                          label[MAX_VERTICES];
    int                          c1, c2;
    logic signed [COST_BITS-1:0] cost;
    tree_edge_t                  te;
    arcs = loaded_arcs;
    nv = active_count();
    for (int i = 1; i < arcs.size(); i++) begin
      t = arcs[i];
      j = i;
      while (j > 0 && arc_precedes(t, arcs[j-1])) begin
        arcs[j] = arcs[j-1];
        j--;
      end
      arcs[j] = t;
    end
    for (int i = 0; i < MAX_VERTICES; i++) label[i] = i;
    accepted = 0;
    cost = '0;
    for (int i = 0; i < arcs.size(); i++) begin
      if (arcs[i].row >= nv || arcs[i].col >= nv) continue;
      c1 = label[arcs[i].row];
      c2 = label[arcs[i].col];
      if (c1 != c2 && accepted < MAX_VERTICES - 1) begin
        for (k = 0; k < nv; k++) if (label[k] == c2) label[k] = c1;
        cost += COST_BITS'(arcs[i].weight);
        te.from_v = arcs[i].row;
        te.to_v = arcs[i].col;
        te.weight = arcs[i].weight;
        te.cost = cost;
        te.valid = 1'b1;
        te.last = 1'b0;
        tree_edges_due.push_back(te);
        accepted++;
      end
    end
    if (accepted == 0) begin
      te = '{default: '0};
      te.last = 1'b1;
      tree_edges_due.push_back(te);
    end else begin
      tree_edges_due[tree_edges_due.size()-1].last = 1'b1;
    end
    loaded_arcs.delete();
  endtask

  task automatic compare_edge();
    tree_edge_t e;
    if (tree_edges_due.size() == 0) begin
      $error("tree edge with nothing expected: from %0d to %0d", from_vertex_o, to_vertex_o);
      fail_count++;
      return;
    end
    e = tree_edges_due.pop_front();
    if (from_vertex_o !== e.from_v) begin
      $error("from_vertex: expected %0d, got %0d", e.from_v, from_vertex_o);
      fail_count++;
    end
    if (to_vertex_o !== e.to_v) begin
      $error("to_vertex: expected %0d, got %0d", e.to_v, to_vertex_o);
      fail_count++;
    end
    if (tree_edge_weight_o !== e.weight) begin
      $error("tree_edge_weight: expected %0d, got %0d", e.weight, tree_edge_weight_o);
      fail_count++;
    end
    if (running_cost_o !== e.cost) begin
      $error("running_cost: expected %0d, got %0d", e.cost, running_cost_o);
      fail_count++;
    end
    if (edge_valid_o !== e.valid) begin
      $error("edge_valid: expected %0d, got %0d", e.valid, edge_valid_o);
      fail_count++;
    end
    if (last_result_o !== e.last) begin
      $error("last_result: expected %0d, got %0d", e.last, last_result_o);
      fail_count++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    int nv;
    arc_t a;
    if (!rst_ni) begin
      vcount = 6'd32;
      loaded_arcs.delete();
      tree_edges_due.delete();
      fail_count = 0;
      tree_count = 0;
    end else begin
      if (out_valid_o && !out_stall_i) compare_edge();
      if (cfg_we_i) vcount = cfg_wdata_i;
      // config and entry never share an edge, so order here is harmless
      if (in_valid_i && !in_stall_o) begin
        nv = active_count();
        if (column_index_i < row_index_i && row_index_i < nv && edge_weight_i != 0
            && loaded_arcs.size() < nv * (nv - 1) / 2
            && loaded_arcs.size() < EDGE_DEPTH) begin
          a.row = row_index_i;
          a.col = column_index_i;
          a.weight = edge_weight_i;
          loaded_arcs.push_back(a);
        end
        if (final_entry_i) begin
          build_tree();
          tree_count++;
        end
      end
    end
  end

endmodule
// ----------------------------------------------------------------------------

>>> test/minimum_spanning_tree_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// minimum_spanning_tree_top_tb
// Loads small weighted matrices under several vertex counts with random idle
// bursts on both channels; the checker predicts and compares each tree.
// ----------------------------------------------------------------------------
module minimum_spanning_tree_top_tb;
  import mst_pkg::*;

  localparam int MAX_VERTICES = 32;
  localparam int WEIGHT_BITS  = 16;
  localparam int TAIL_CYCLES  = 200;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b1;
  logic                          cfg_we_i = 1'b0;
  logic [5:0]                    cfg_wdata_i = '0;
  logic                          in_valid_i = 1'b0;
  logic                          in_stall_o;
  logic [VERTEX_BITS-1:0]        row_index_i = '0;
  logic [VERTEX_BITS-1:0]        column_index_i = '0;
  logic signed [WEIGHT_BITS-1:0] edge_weight_i = '0;
  logic                          final_entry_i = 1'b0;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  logic [VERTEX_BITS-1:0]        from_vertex_o;
  logic [VERTEX_BITS-1:0]        to_vertex_o;
  logic signed [WEIGHT_BITS-1:0] tree_edge_weight_o;
  logic signed [COST_BITS-1:0]   running_cost_o;
  logic                          edge_valid_o;
  logic                          last_result_o;

  int fail_count, pending_count, tree_count;
  int entries_sent = 0;
  bit calm = 1'b0;           // last part of the run: no idling
  bit long_hold = 1'b0;      // ask the receiver for one long hold-off

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  minimum_spanning_tree_top #(
    .MAX_VERTICES(MAX_VERTICES),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) DUT (.*);

  minimum_spanning_tree_checker #(
    .MAX_VERTICES(MAX_VERTICES),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) checker_i (.*);

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      if (long_hold) begin
        out_stall_i <= 1'b1;
        repeat (400) @(posedge clk_i);
        long_hold = 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 13);
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end else begin
        out_stall_i <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
    end
  end

  // offer one entry and hold it until taken; stall is sampled mid-cycle
  task automatic send_entry(int r, int c, int w, bit fin);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    row_index_i <= r[VERTEX_BITS-1:0];
    column_index_i <= c[VERTEX_BITS-1:0];
    edge_weight_i <= w[WEIGHT_BITS-1:0];
    final_entry_i <= fin;
    @(negedge clk_i);
    while (in_stall_o) @(negedge clk_i);
    @(posedge clk_i);
    entries_sent++;
  endtask

  // drop valid, wait for every tree edge, then let the block settle
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  // drop valid so that no entry is taken on the write edge
  task automatic set_vertices(int v);
    in_valid_i <= 1'b0;
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v[5:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // random small matrix, mostly lower-triangle edges with some noise
  task automatic random_matrix(int nv, int entries);
    int r, c, w;
    for (int i = 0; i < entries; i++) begin
      r = $urandom_range(0, nv - 1 > 0 ? nv - 1 : 0);
      c = $urandom_range(0, r > 0 ? r - 1 : 0);
      case ($urandom_range(0, 9))
        0: w = 0;
        1: begin
          r = $urandom_range(0, 31);
          c = $urandom_range(0, 31);
          w = $urandom_range(0, 65535);
        end
        2: w = $urandom_range(0, 1) ? 32'h7fff : -32768;
        3: w = $urandom_range(0, 65535);
        default: w = int'($urandom_range(0, 15)) - 7;
      endcase
      send_entry(r, c, w, i == entries - 1);
    end
  endtask

  initial begin
    rst_ni <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: default vertex count, extremes of weights and indexes
    send_entry(31, 0, 32'h7fff, 1'b0);
    send_entry(31, 30, -32768, 1'b0);
    send_entry(0, 31, 5, 1'b0);          // above diagonal: ignored
    send_entry(7, 7, 3, 1'b0);           // diagonal: ignored
    send_entry(20, 10, 0, 1'b0);         // zero weight: no edge
    send_entry(30, 0, -32768, 1'b0);     // tie on weight
    send_entry(5, 2, 1, 1'b0);
    send_entry(5, 2, 1, 1'b0);           // repeated position
    send_entry(2, 1, -1, 1'b1);
    drain();
    // empty tree
    send_entry(3, 1, 0, 1'b1);
    drain();
    // vertex count 1 and 0: nothing qualifies
    set_vertices(1);
    send_entry(1, 0, 9, 1'b1);
    drain();
    set_vertices(0);
    send_entry(4, 2, 9, 1'b1);
    drain();
    // count above the maximum acts as the maximum; overflow the store at 3
    set_vertices(63);
    send_entry(31, 16, 21845, 1'b1);
    drain();
    set_vertices(3);
    for (int i = 0; i < 4; i++) send_entry(2, i % 2, 100 - i, 1'b0);
    send_entry(1, 0, 7, 1'b1);
    drain();
    // lower the count during the load
    set_vertices(6);
    send_entry(5, 4, -3, 1'b0);
    send_entry(3, 0, 2, 1'b0);
    set_vertices(4);
    send_entry(2, 1, 4, 1'b1);
    drain();

    // random phases over several vertex counts
    while (entries_sent < 270) begin
      int nv;
      nv = $urandom_range(0, 4) == 0 ? $urandom_range(9, 32) : $urandom_range(2, 8);
      if (entries_sent > 230) calm = 1'b1;
      set_vertices(nv);
      if (tree_count == 12) begin
        // keep offering while the receiver holds off: the block fills and stalls
        long_hold = 1'b1;
        random_matrix(nv, 3);
        random_matrix(nv, 3);
      end
      random_matrix(nv, $urandom_range(1, 12));
      drain();
    end

    in_valid_i <= 1'b0;
    drain();
    $display("covered %0d entries and %0d trees, vertex counts 0 to 63, weight extremes",
             entries_sent, tree_count);
    if (fail_count == 0) begin
      $display("** minimum_spanning_tree_top: PASSED **");
    end else begin
      $display("** minimum_spanning_tree_top: FAILED **");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("** minimum_spanning_tree_top: FAILED **");
    $finish;
  end

endmodule
// ----------------------------------------------------------------------------
